// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the alu controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/alu32f_pkg.sv =====
// types, opcodes and decode shared by the alu modules
package alu32f_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned CntW  = 5;
	localparam logic [CntW-1:0] DivLast = CntW'(WordW - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ADD,
		OP_ADC,
		OP_SUB,
		OP_SBB,
		OP_MUL,
		OP_DIV,
		OP_SHL,
		OP_SHR,
		OP_ROL,
		OP_ROR,
		OP_AND,
		OP_OR,
		OP_XOR,
		OP_NOT
	} op_t;

	typedef struct packed {
		logic load_in;
		logic calc;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_div;
	} sts_t;

	function automatic op_t decode_op(input logic [7:0] m);
		op_t op;
		op = OP_NONE;
		if (m[6]) begin
			if (m[5]) begin
				if (m[4])
					op = m[3] ? OP_XOR : OP_OR;
				else
					op = m[3] ? OP_NOT : OP_AND;
			end else if (m[4]) begin
				op = m[2] ? OP_ROR : OP_ROL;
			end else begin
				op = m[2] ? OP_SHR : OP_SHL;
			end
		end else if (m[5]) begin
			if (!m[3])
				op = m[4] ? OP_DIV : OP_MUL;
		end else if (!m[4]) begin
			if (m[3])
				op = m[2] ? OP_SBB : OP_SUB;
			else
				op = m[2] ? OP_ADC : OP_ADD;
		end
		return op;
	endfunction

endpackage

// ===== hw/rtl/alu_32bit_with_flags_unit.sv =====
// top level of the 32-bit alu with flags
//
// channel  handshake            word
// in       in_valid / in_stall  base_operand, second_operand, mode
// out      out_valid / out_stall result_value, carry_out, zero_out, negative_out, overflow_out
//
// one word at a time: accept, calculate, output load
// simple operations go straight from calculate to output load; divide adds one divider step per quotient bit
// the restoring divider produces one quotient bit per cycle
// reset clears the carry flag and the controller; no clearing pass
// a stalled output holds the next result in the datapath until the output register frees
module alu_32bit_with_flags_unit
	import alu32f_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WordW-1:0] base_operand,
	input  logic [WordW-1:0] second_operand,
	input  logic [7:0]       mode,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WordW-1:0] result_value,
	output logic             carry_out,
	output logic             zero_out,
	output logic             negative_out,
	output logic             overflow_out
);

	cmd_t cmd;
	sts_t sts;

	alu32f_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	alu32f_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.base_operand   (base_operand),
		.second_operand (second_operand),
		.mode           (mode),
		.result_value   (result_value),
		.carry_out      (carry_out),
		.zero_out       (zero_out),
		.negative_out   (negative_out),
		.overflow_out   (overflow_out)
	);

endmodule

// ===== hw/rtl/alu32f_ctrl.sv =====
// controller state machine: input handshake, divide sequencing, output handshake
`include "assert_macros.svh"

module alu32f_ctrl
	import alu32f_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [CntW-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_CALC;
			end
			ST_CALC: begin
				state_d = sts.is_div ? ST_DIV : ST_FIN;
			end
			ST_DIV: begin
				if (cnt_q == DivLast)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_CALC: cmd.calc = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_FIN: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.calc)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + CntW'(1);
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_NEXT(a_accept_calc, clk, arst_n, in_valid && !in_stall, state_q == ST_CALC,
		"accepted word did not start calculation")
	`ASSERT_NEXT(a_div_end, clk, arst_n, state_q == ST_DIV && cnt_q == DivLast,
		state_q == ST_FIN, "divide did not finish after last step")
	`ASSERT_SAME(a_load_free, clk, arst_n, cmd.load_out, !out_valid_q || !out_stall,
		"output overwritten while stalled")

endmodule

// ===== hw/rtl/alu32f_dp.sv =====
// datapath: operand registers, alu, restoring divider, carry and output registers
module alu32f_dp
	import alu32f_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [WordW-1:0]  base_operand,
	input  logic [WordW-1:0]  second_operand,
	input  logic [7:0]        mode,
	output logic [WordW-1:0]  result_value,
	output logic              carry_out,
	output logic              zero_out,
	output logic              negative_out,
	output logic              overflow_out
);

	logic [WordW-1:0] a_q, b_q, res_q, quo_q, rem_q;
	op_t op_q;
	logic carry_q, newc_q, updc_q;

	logic [WordW:0]     sum;
	logic [2*WordW-1:0] prod;
	logic [2*WordW-1:0] rot_l, rot_r;
	logic [WordW-1:0]   alu_res;
	logic [WordW:0]     rem_pre, diff;
	logic [WordW-1:0]   fin_res;

	assign sts.is_div = (op_q == OP_DIV);

	always_comb begin
		unique case (op_q)
			OP_ADD: sum = {1'b0, a_q} + {1'b0, b_q};
			OP_ADC: sum = {1'b0, a_q} + {1'b0, b_q} + {{WordW{1'b0}}, carry_q};
			OP_SUB: sum = {1'b0, a_q} + {1'b0, ~b_q} + {{WordW{1'b0}}, 1'b1};
			default: sum = {1'b0, a_q} + {1'b0, ~b_q} + {{WordW{1'b0}}, carry_q};
		endcase
	end

	assign prod  = {{WordW{1'b0}}, a_q} * {{WordW{1'b0}}, b_q};
	assign rot_l = {a_q, a_q} << b_q[CntW-1:0];
	assign rot_r = {a_q, a_q} >> b_q[CntW-1:0];

	always_comb begin
		unique case (op_q)
			OP_ADD, OP_ADC, OP_SUB, OP_SBB: alu_res = sum[WordW-1:0];
			OP_MUL: alu_res = prod[WordW-1:0];
			OP_SHL: alu_res = (|b_q[WordW-1:CntW]) ? '0 : (a_q << b_q[CntW-1:0]);
			OP_SHR: alu_res = (|b_q[WordW-1:CntW]) ? '0 : (a_q >> b_q[CntW-1:0]);
			OP_ROL: alu_res = rot_l[2*WordW-1:WordW];
			OP_ROR: alu_res = rot_r[WordW-1:0];
			OP_AND: alu_res = a_q & b_q;
			OP_OR:  alu_res = a_q | b_q;
			OP_XOR: alu_res = a_q ^ b_q;
			OP_NOT: alu_res = ~a_q;
			default: alu_res = '0;
		endcase
	end

	// one quotient bit per step; a zero divisor yields all ones
	assign rem_pre = {rem_q, quo_q[WordW-1]};
	assign diff    = rem_pre - {1'b0, b_q};

	assign fin_res = sts.is_div ? quo_q : res_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			a_q  <= base_operand;
			b_q  <= second_operand;
			op_q <= decode_op(mode);
		end
		if (cmd.calc) begin
			res_q  <= alu_res;
			newc_q <= sum[WordW];
			updc_q <= (op_q == OP_ADD) || (op_q == OP_ADC);
			rem_q  <= '0;
			quo_q  <= a_q;
		end else if (cmd.div_step) begin
			rem_q <= diff[WordW] ? rem_pre[WordW-1:0] : diff[WordW-1:0];
			quo_q <= {quo_q[WordW-2:0], ~diff[WordW]};
		end
		if (cmd.load_out) begin
			result_value <= fin_res;
			zero_out     <= (fin_res == '0);
			negative_out <= fin_res[WordW-1];
			overflow_out <= fin_res[WordW-1] && !a_q[WordW-1];
			carry_out    <= updc_q ? newc_q : carry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			carry_q <= 1'b0;
		else if (cmd.load_out && updc_q)
			carry_q <= newc_q;
	end

endmodule

// ===== tb/alu_32bit_with_flags_unit_tb.sv =====
// testbench for the 32-bit alu with flags: directed and random words checked against a predictor
module alu_32bit_with_flags_unit_tb;
	import alu32f_pkg::*;

	localparam logic [7:0] MODE_ADD       = 8'h00;
	localparam logic [7:0] MODE_ADC       = 8'h04;
	localparam logic [7:0] MODE_SUB       = 8'h08;
	localparam logic [7:0] MODE_SBB       = 8'h0C;
	localparam logic [7:0] MODE_MUL       = 8'h20;
	localparam logic [7:0] MODE_DIV       = 8'h30;
	localparam logic [7:0] MODE_SHL       = 8'h40;
	localparam logic [7:0] MODE_SHR       = 8'h44;
	localparam logic [7:0] MODE_ROL       = 8'h50;
	localparam logic [7:0] MODE_ROR       = 8'h54;
	localparam logic [7:0] MODE_AND       = 8'h60;
	localparam logic [7:0] MODE_NOT       = 8'h68;
	localparam logic [7:0] MODE_OR        = 8'h70;
	localparam logic [7:0] MODE_XOR       = 8'h78;
	localparam logic [7:0] MODE_BAD_ARITH = 8'h10;
	localparam logic [7:0] MODE_BAD_MULDV = 8'h28;
	localparam logic [7:0] MODE_IGNORED   = 8'h83;
	localparam logic [7:0] MODE_LIST [16] = '{
		MODE_ADD, MODE_ADC, MODE_SUB, MODE_SBB, MODE_MUL, MODE_DIV, MODE_SHL, MODE_SHR,
		MODE_ROL, MODE_ROR, MODE_AND, MODE_NOT, MODE_OR, MODE_XOR, MODE_BAD_ARITH,
		MODE_BAD_MULDV
	};
	localparam logic [WordW-1:0] ALL_ONES = '1;
	localparam logic [WordW-1:0] SIGN_ONLY = 32'h8000_0000;
	localparam logic [WordW-1:0] MAX_POS = 32'h7FFF_FFFF;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [WordW-1:0] value;
		logic             carry;
		logic             zero;
		logic             negative;
		logic             overflow;
	} alu_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [WordW-1:0] base_operand = '0;
	logic [WordW-1:0] second_operand = '0;
	logic [7:0]       mode = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [WordW-1:0] result_value;
	logic             carry_out;
	logic             zero_out;
	logic             negative_out;
	logic             overflow_out;

	alu_result_t expected_results [$];
	logic        carry_flag = 1'b0;
	int          mismatch_count = 0;
	bit          idling_on = 1'b1;
	int          stall_left = 0;

	alu_32bit_with_flags_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.base_operand(base_operand),
		.second_operand(second_operand),
		.mode(mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.carry_out(carry_out),
		.zero_out(zero_out),
		.negative_out(negative_out),
		.overflow_out(overflow_out)
	);

	always #4 clk = ~clk;

	function automatic op_t classify_mode(input logic [7:0] m);
		op_t op;
		casez (m[6:2])
			5'b1111?: op = OP_XOR;
			5'b1110?: op = OP_OR;
			5'b1101?: op = OP_NOT;
			5'b1100?: op = OP_AND;
			5'b101?1: op = OP_ROR;
			5'b101?0: op = OP_ROL;
			5'b100?1: op = OP_SHR;
			5'b100?0: op = OP_SHL;
			5'b0110?: op = OP_DIV;
			5'b0100?: op = OP_MUL;
			5'b00011: op = OP_SBB;
			5'b00010: op = OP_SUB;
			5'b00001: op = OP_ADC;
			5'b00000: op = OP_ADD;
			default:  op = OP_NONE;
		endcase
		return op;
	endfunction

	// updates the kept carry as the block does
	function automatic alu_result_t predict_alu(input logic [WordW-1:0] a, b,
			input logic [7:0] m);
		alu_result_t res;
		logic [WordW-1:0] r;
		logic [WordW:0] sum;
		logic [2*WordW-1:0] rot;
		r = '0;
		case (classify_mode(m))
			OP_ADD, OP_ADC: begin
				sum = {1'b0, a} + {1'b0, b};
				if (classify_mode(m) == OP_ADC)
					sum = sum + {{WordW{1'b0}}, carry_flag};
				r = sum[WordW-1:0];
				carry_flag = sum[WordW];
			end
			OP_SUB: r = a - b;
			OP_SBB: r = a - b - 32'd1 + {{(WordW-1){1'b0}}, carry_flag};
			OP_MUL: r = a * b;
			OP_DIV: r = (b == '0) ? ALL_ONES : a / b;
			OP_SHL: r = (b >= WordW) ? '0 : a << b;
			OP_SHR: r = (b >= WordW) ? '0 : a >> b;
			OP_ROL: begin
				rot = {a, a} << b[4:0];
				r = rot[2*WordW-1:WordW];
			end
			OP_ROR: begin
				rot = {a, a} >> b[4:0];
				r = rot[WordW-1:0];
			end
			OP_AND: r = a & b;
			OP_OR:  r = a | b;
			OP_XOR: r = a ^ b;
			OP_NOT: r = ~a;
			default: r = '0;
		endcase
		res.value = r;
		res.carry = carry_flag;
		res.zero = (r == '0);
		res.negative = r[WordW-1];
		res.overflow = r[WordW-1] && !a[WordW-1];
		return res;
	endfunction

	function automatic logic [WordW-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ALL_ONES;
			2: return SIGN_ONLY;
			3: return MAX_POS;
			4, 5: return WordW'($urandom_range(0, 40));
			default: return WordW'($urandom());
		endcase
	endfunction

	function automatic logic [7:0] pick_mode();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return MODE_LIST[$urandom_range(0, 15)] | (8'($urandom()) & MODE_IGNORED);
	endfunction

	task automatic send_word(input logic [WordW-1:0] a, b, input logic [7:0] m);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		base_operand <= a;
		second_operand <= b;
		mode <= m;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(predict_alu(a, b, m));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_word('0, '0, MODE_ADC);
		send_word(ALL_ONES, 32'd1, MODE_ADD);
		send_word('0, '0, MODE_ADC);
		send_word(ALL_ONES, ALL_ONES, MODE_ADC);
		send_word(MAX_POS, 32'd1, MODE_ADD);
		send_word('0, 32'd1, MODE_SUB);
		send_word(32'd5, 32'd5, MODE_SBB);
		send_word(32'd1, 32'd2, MODE_ADD);
		send_word(32'd5, 32'd5, MODE_SBB);
		send_word(ALL_ONES, ALL_ONES, MODE_MUL);
		send_word(32'd1234, '0, MODE_DIV);
		send_word(ALL_ONES, 32'd1, MODE_DIV);
		send_word(32'd7, 32'd2, MODE_DIV);
		send_word(32'd1, 32'd31, MODE_SHL);
		send_word(ALL_ONES, 32'd32, MODE_SHL);
		send_word(ALL_ONES, ALL_ONES, MODE_SHR);
		send_word(SIGN_ONLY, 32'd31, MODE_SHR);
		send_word(32'h1234_5678, '0, MODE_ROL);
		send_word(SIGN_ONLY, 32'd33, MODE_ROL);
		send_word(32'd1, 32'd31, MODE_ROR);
		send_word(32'hF0F0_F0F0, 32'hFF00_FF00, MODE_AND | MODE_IGNORED);
		send_word(MAX_POS, SIGN_ONLY, MODE_OR);
		send_word(ALL_ONES, 32'h5555_5555, 8'hFF);
		send_word(MAX_POS, '0, MODE_NOT);
		send_word(ALL_ONES, ALL_ONES, MODE_BAD_ARITH);
		send_word(ALL_ONES, ALL_ONES, MODE_BAD_MULDV);
	endtask

	task automatic test_random_words(input int count);
		for (int i = 0; i < count; i++) begin
			idling_on = ((i / 100) % 3) != 2;
			send_word(pick_operand(), pick_operand(), pick_mode());
		end
		idling_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		for (int n = 0; n < 3; n++) begin
			repeat (12) send_word(pick_operand(), pick_operand(), pick_mode());
			wait_drained();
		end
	endtask

	task automatic test_steady_tail(input int count);
		idling_on = 1'b0;
		for (int i = 0; i < count; i++)
			send_word(pick_operand(), pick_operand(), pick_mode());
	endtask

	// receiver stall in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 12);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		alu_result_t exp_word;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result word %h", result_value);
				mismatch_count++;
			end else begin
				exp_word = expected_results.pop_front();
				if (result_value !== exp_word.value) begin
					$error("result_value expected %h actual %h", exp_word.value, result_value);
					mismatch_count++;
				end
				if (carry_out !== exp_word.carry) begin
					$error("carry_out expected %b actual %b", exp_word.carry, carry_out);
					mismatch_count++;
				end
				if (zero_out !== exp_word.zero) begin
					$error("zero_out expected %b actual %b", exp_word.zero, zero_out);
					mismatch_count++;
				end
				if (negative_out !== exp_word.negative) begin
					$error("negative_out expected %b actual %b", exp_word.negative,
						negative_out);
					mismatch_count++;
				end
				if (overflow_out !== exp_word.overflow) begin
					$error("overflow_out expected %b actual %b", exp_word.overflow,
						overflow_out);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_words(700);
		test_drain_pause();
		test_steady_tail(340);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("alu_32bit_with_flags_unit test passed");
		else
			$display("alu_32bit_with_flags_unit test failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("alu_32bit_with_flags_unit test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/alu32f_pkg.sv
hw/rtl/alu32f_ctrl.sv
hw/rtl/alu32f_dp.sv
hw/rtl/alu_32bit_with_flags_unit.sv
tb/alu_32bit_with_flags_unit_tb.sv
